>>> hdl/dqe_pkg.sv
// ----------------------------------------------------------------------------
// dqe_pkg
// Shared types, constants and byte tables for the DNS query encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dqe_pkg;

	// label buffer depth: characters past this in one label are dropped
	localparam int LABEL_MAX = 32;

	localparam int LBL_AW  = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
	localparam int LCNT_W  = $clog2(LABEL_MAX + 1);
	localparam int BCNT_W  = ($clog2(LABEL_MAX) > 4) ? $clog2(LABEL_MAX) : 4;

	localparam logic [7:0]  DOT_CHAR  = 8'd46;
	localparam logic [15:0] DNS_FLAGS = 16'h0100;

	localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
	localparam logic [3:0] TAIL_LAST_IDX = 4'd4;

	localparam logic [1:0] REG_QUERY_ID    = 2'd0;
	localparam logic [1:0] REG_QUERY_TYPE  = 2'd1;
	localparam logic [1:0] REG_QUERY_CLASS = 2'd2;

	typedef enum logic [1:0] {
		SRC_HDR  = 2'd0,
		SRC_LEN  = 2'd1,
		SRC_DATA = 2'd2,
		SRC_TAIL = 2'd3
	} src_t;

	typedef struct packed {
		logic load_char;
		logic emit;
		src_t src;
		logic last;
		logic cnt_clr;
		logic cnt_inc;
		logic label_clr;
		logic hdr_set;
		logic hdr_clr;
	} cmd_t;

	typedef struct packed {
		logic              in_dot;
		logic              in_end;
		logic              dot_q;
		logic              end_q;
		logic              header_done;
		logic              count_zero;
		logic              label_end;
		logic              hdr_end;
		logic              tail_end;
		logic              out_free;
		logic [LCNT_W-1:0] label_count;
	} sts_t;

	// 12-byte header: ID, flags, one question, zero counts
	function automatic logic [7:0] hdr_byte(input logic [3:0] idx, input logic [15:0] id);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = id[15:8];
			4'd1:    b = id[7:0];
			4'd2:    b = DNS_FLAGS[15:8];
			4'd3:    b = DNS_FLAGS[7:0];
			4'd5:    b = 8'd1;
			default: b = 8'd0;
		endcase
		return b;
	endfunction

	// terminator, then QTYPE and QCLASS big-endian
	function automatic logic [7:0] tail_byte(input logic [3:0] idx, input logic [15:0] qtype,
						 input logic [15:0] qclass);
		logic [7:0] b;
		unique case (idx)
			4'd1:    b = qtype[15:8];
			4'd2:    b = qtype[7:0];
			4'd3:    b = qclass[15:8];
			4'd4:    b = qclass[7:0];
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

>>> hdl/dqe_ctrl.sv
// ----------------------------------------------------------------------------
// dqe_ctrl
// Sequencer: header, label flush and trailer byte phases.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_ctrl import dqe_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic name_valid,
	output logic      name_stall,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_HDR  = 5'b00010,
		ST_LEN  = 5'b00100,
		ST_DATA = 5'b01000,
		ST_TAIL = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign name_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd     = '0;
		cmd.src = SRC_HDR;
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (name_valid) begin
					// character is stored at the transfer; header never reads the label
					cmd.load_char = 1'b1;
					cmd.cnt_clr   = 1'b1;
					if (!sts.header_done)
						state_d = ST_HDR;
					else if (sts.in_dot || sts.in_end)
						state_d = ST_LEN;
				end
			end
			ST_HDR: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_HDR;
					if (sts.hdr_end) begin
						cmd.cnt_clr = 1'b1;
						cmd.hdr_set = 1'b1;
						state_d = (sts.dot_q || sts.end_q) ? ST_LEN : ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_LEN: begin
				if (sts.out_free) begin
					cmd.emit    = 1'b1;
					cmd.src     = SRC_LEN;
					cmd.cnt_clr = 1'b1;
					if (sts.count_zero) begin
						cmd.label_clr = 1'b1;
						state_d = sts.end_q ? ST_TAIL : ST_IDLE;
					end else begin
						state_d = ST_DATA;
					end
				end
			end
			ST_DATA: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_DATA;
					if (sts.label_end) begin
						cmd.label_clr = 1'b1;
						cmd.cnt_clr   = 1'b1;
						state_d = sts.end_q ? ST_TAIL : ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			ST_TAIL: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					cmd.src  = SRC_TAIL;
					if (sts.tail_end) begin
						cmd.last    = 1'b1;
						cmd.hdr_clr = 1'b1;
						cmd.cnt_clr = 1'b1;
						state_d = ST_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/dqe_dp.sv
// ----------------------------------------------------------------------------
// dqe_dp
// Datapath: config registers, label buffer, byte counter, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dqe_dp import dqe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic [7:0]  name_char,
	input  wire logic        name_end,
	output logic             msg_valid,
	input  wire logic        msg_stall,
	output logic [7:0]       msg_byte,
	output logic             msg_last,
	output logic             label_truncated,
	input  wire cmd_t        cmd,
	output sts_t             sts
);

	logic [15:0]       query_id_q, query_type_q, query_class_q;
	logic [7:0]        label_store [LABEL_MAX];
	logic [LCNT_W-1:0] label_count_q;
	logic              overflow_q;
	logic              header_done_q;
	logic              dot_q, end_q;
	logic [BCNT_W-1:0] cnt_q;
	logic              out_valid_q, out_last_q, out_trunc_q;
	logic [7:0]        out_byte_q;

	logic              in_dot;
	logic              room;
	logic [7:0]        byte_d;
	logic              trunc_d;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q    <= 16'd1;
			query_type_q  <= 16'd1;
			query_class_q <= 16'd1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_QUERY_ID:    query_id_q    <= cfg_data;
				REG_QUERY_TYPE:  query_type_q  <= cfg_data;
				REG_QUERY_CLASS: query_class_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_dot = (name_char == DOT_CHAR);
	assign room   = (label_count_q < LCNT_W'(LABEL_MAX));

	always_ff @(posedge clk) begin
		if (cmd.load_char && !in_dot && room)
			label_store[label_count_q[LBL_AW-1:0]] <= name_char;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			label_count_q <= '0;
			overflow_q    <= 1'b0;
			header_done_q <= 1'b0;
			dot_q         <= 1'b0;
			end_q         <= 1'b0;
			cnt_q         <= '0;
		end else begin
			if (cmd.load_char) begin
				dot_q <= in_dot;
				end_q <= name_end;
				if (!in_dot) begin
					if (room)
						label_count_q <= label_count_q + 1'b1;
					else
						overflow_q <= 1'b1;
				end
			end
			if (cmd.label_clr) begin
				label_count_q <= '0;
				overflow_q    <= 1'b0;
			end
			if (cmd.hdr_set)
				header_done_q <= 1'b1;
			else if (cmd.hdr_clr)
				header_done_q <= 1'b0;
			if (cmd.cnt_clr)
				cnt_q <= '0;
			else if (cmd.cnt_inc)
				cnt_q <= cnt_q + 1'b1;
		end
	end

	always_comb begin
		byte_d  = 8'd0;
		trunc_d = 1'b0;
		unique case (cmd.src)
			SRC_HDR:  byte_d = hdr_byte(cnt_q[3:0], query_id_q);
			SRC_LEN: begin
				byte_d  = 8'(label_count_q);
				trunc_d = overflow_q;
			end
			SRC_DATA: begin
				trunc_d = overflow_q;
			end
			SRC_TAIL: byte_d = tail_byte(cnt_q[3:0], query_type_q, query_class_q);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!msg_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			// label bytes come straight out of the buffer
			if (cmd.src == SRC_DATA)
				out_byte_q <= label_store[cnt_q[LBL_AW-1:0]];
			else
				out_byte_q <= byte_d;
			out_last_q  <= cmd.last;
			out_trunc_q <= trunc_d;
		end
	end

	assign msg_valid       = out_valid_q;
	assign msg_byte        = out_byte_q;
	assign msg_last        = out_last_q;
	assign label_truncated = out_trunc_q;

	assign sts.in_dot      = in_dot;
	assign sts.in_end      = name_end;
	assign sts.dot_q       = dot_q;
	assign sts.end_q       = end_q;
	assign sts.header_done = header_done_q;
	assign sts.count_zero  = (label_count_q == '0);
	assign sts.label_end   = ((BCNT_W + 1)'(cnt_q) + 1'b1) == (BCNT_W + 1)'(label_count_q);
	assign sts.hdr_end     = (cnt_q == BCNT_W'(HDR_LAST_IDX));
	assign sts.tail_end    = (cnt_q == BCNT_W'(TAIL_LAST_IDX));
	assign sts.out_free    = !out_valid_q || !msg_stall;
	assign sts.label_count = label_count_q;

endmodule

`default_nettype wire

>>> hdl/dns_query_encoder.sv
// ----------------------------------------------------------------------------
// dns_query_encoder
// Encodes a dotted domain name, one character per transfer, into a DNS query
// message streamed out one byte per transfer.
// ----------------------------------------------------------------------------
//  channel | signals                                   | flow control
//  name    | name_char[7:0], name_end                  | name_valid / name_stall
//  msg     | msg_byte[7:0], msg_last, label_truncated  | msg_valid / msg_stall
//  cfg     | cfg_index[1:0], cfg_data[15:0]            | cfg_valid / cfg_ready
//
// A plain character is stored in the label buffer while it has room. The first
// character of a message adds the 12-byte header; a dot or the last character
// adds a length and label flush, and the last also adds the trailer. The output
// register sends one byte per cycle; msg_stall holds the sequencer in place.
// Reset clears the label count and header flag and sets the config regs to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_query_encoder import dqe_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        name_valid,
	output logic             name_stall,
	input  wire logic [7:0]  name_char,
	input  wire logic        name_end,
	output logic             msg_valid,
	input  wire logic        msg_stall,
	output logic [7:0]       msg_byte,
	output logic             msg_last,
	output logic             label_truncated
);

	cmd_t cmd;
	sts_t sts;

	dqe_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.name_valid (name_valid),
		.name_stall (name_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	dqe_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.name_char       (name_char),
		.name_end        (name_end),
		.msg_valid       (msg_valid),
		.msg_stall       (msg_stall),
		.msg_byte        (msg_byte),
		.msg_last        (msg_last),
		.label_truncated (label_truncated),
		.cmd             (cmd),
		.sts             (sts)
	);

	// the final byte never belongs to a label
	a_last_not_trunc: assert property (@(posedge clk) disable iff (!arst_n)
		msg_valid && msg_last |-> !label_truncated)
		else $error("last byte flagged truncated");

	// the end of a name always starts a flush and trailer
	a_end_busy: assert property (@(posedge clk) disable iff (!arst_n)
		name_valid && !name_stall && name_end |=> name_stall)
		else $error("name end accepted without trailer");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sts.label_count <= LCNT_W'(LABEL_MAX))
		else $error("label count past buffer depth");

	// a byte only enters the output register when it is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!msg_valid || !msg_stall))
		else $error("output register overwritten");

endmodule

`default_nettype wire
